@@ src/lru_key_cache_assert.svh @@
// lru_key_cache_assert.svh: assertion macros for the lru key cache
// expects signals named clock and reset in the module that uses them
`ifndef LRU_KEY_CACHE_ASSERT_SVH
`define LRU_KEY_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
`define LKC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lru_key_cache assertion failed");
`define LKC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lru_key_cache assertion failed");
`else
`define LKC_ASSERT_NOW(label, ante, cons)
`define LKC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ src/lkc_pkg.sv @@
// lkc_pkg: shared constants and types of the lru key cache
// no dependencies
`timescale 1ns / 1ps

package lkc_pkg;

   localparam int DEF_ENTRIES = 16;
   localparam int KEY_W       = 32;
   localparam int CAP_W       = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef struct packed {
      logic capture;
      logic commit;
   } lkc_cmd_type;

endpackage

@@ src/lkc_ctrl.sv @@
// lkc_ctrl: sequencer of the lru key cache, input and output handshakes
// depends on lkc_pkg
`timescale 1ns / 1ps

module lkc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lkc_pkg::lkc_cmd_type cmd
);
   import lkc_pkg::*;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_UPDATE = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/lkc_dpath.sv @@
// lkc_dpath: key store, recency ranks, occupancy, capacity and result word
// depends on lkc_pkg, driven by lkc_ctrl commands
`timescale 1ns / 1ps

module lkc_dpath #(
   parameter int ENTRIES = lkc_pkg::DEF_ENTRIES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lkc_pkg::lkc_cmd_type        cmd,
   input  logic                        csr_we,
   input  logic [lkc_pkg::CAP_W-1:0]   csr_data,
   input  logic                        req_cmd,
   input  logic signed [lkc_pkg::KEY_W-1:0] req_key,
   output logic                        rsp_hit,
   output logic                        rsp_evicted_valid,
   output logic signed [lkc_pkg::KEY_W-1:0] rsp_evicted_key
);
   import lkc_pkg::*;

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   // store
   logic [KEY_W-1:0]   keys_ff  [ENTRIES];
   logic [KEY_W-1:0]   keys_in  [ENTRIES];
   logic [RANK_W-1:0]  rank_ff  [ENTRIES];
   logic [RANK_W-1:0]  rank_in  [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [OCC_W-1:0]   occ_ff;
   logic [OCC_W-1:0]   occ_in;
   logic [CAP_W-1:0]   cap_ff;
   logic [CAP_W-1:0]   cap_in;

   // word captured with its compare results
   logic               op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic               hit_ff;
   logic               full_ff;
   logic [RANK_W-1:0]  hit_rank_ff;
   logic [ENTRIES-1:0] match_ff;
   logic [ENTRIES-1:0] lru_ff;
   logic [ENTRIES-1:0] free_ff;

   logic [ENTRIES-1:0] match_vec;
   logic [ENTRIES-1:0] lru_vec;
   logic [ENTRIES-1:0] free_vec;
   logic [RANK_W-1:0]  hit_rank;
   logic [RANK_W-1:0]  lru_rank;
   logic [OCC_W-1:0]   occ_m1;
   logic               full;

   // result word
   logic               res_hit_ff;
   logic               res_hit_in;
   logic               res_ev_valid_ff;
   logic               res_ev_valid_in;
   logic [KEY_W-1:0]   res_ev_key_ff;
   logic [KEY_W-1:0]   res_ev_key_in;

   logic               evict;
   logic [KEY_W-1:0]   lru_key;
   logic [ENTRIES-1:0] target;

   // compare stage
   assign occ_m1   = occ_ff - OCC_W'(1);
   assign lru_rank = occ_m1[RANK_W-1:0];
   assign free_vec = ~valid_ff & (valid_ff + ENTRIES'(1));
   assign full     = (occ_ff != '0) &&
                     ((CMP_W'(occ_ff) >= CMP_W'(cap_ff)) || (occ_ff == OCC_W'(ENTRIES)));

   always_comb begin
      hit_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match_vec[i] = valid_ff[i] && (keys_ff[i] == req_key);
         lru_vec[i]   = valid_ff[i] && (rank_ff[i] == lru_rank);
         hit_rank     = hit_rank | (rank_ff[i] & {RANK_W{match_vec[i]}});
      end
   end

   // update stage
   assign evict  = (op_ff == CMD_INSERT) && !hit_ff && full_ff;
   assign target = full_ff ? lru_ff : free_ff;

   always_comb begin
      lru_key = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         lru_key = lru_key | (keys_ff[i] & {KEY_W{lru_ff[i]}});
      end
   end

   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         keys_in[i] = keys_ff[i];
         rank_in[i] = rank_ff[i];
      end
      if (cmd.commit && (op_ff == CMD_INSERT)) begin
         if (hit_ff) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (match_ff[i]) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
         end else begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (target[i]) begin
                  keys_in[i]  = key_ff;
                  rank_in[i]  = '0;
                  valid_in[i] = 1'b1;
               end else if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
            if (!full_ff) begin
               occ_in = occ_ff + OCC_W'(1);
            end
         end
      end
   end

   always_comb begin
      res_hit_in      = res_hit_ff;
      res_ev_valid_in = res_ev_valid_ff;
      res_ev_key_in   = res_ev_key_ff;
      if (cmd.commit) begin
         res_hit_in      = hit_ff;
         res_ev_valid_in = evict;
         res_ev_key_in   = evict ? lru_key : '0;
      end
   end

   assign cap_in = csr_we ? csr_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         cap_ff   <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         keys_ff[i] <= keys_in[i];
         rank_ff[i] <= rank_in[i];
      end
      if (cmd.capture) begin
         op_ff       <= req_cmd;
         key_ff      <= req_key;
         hit_ff      <= |match_vec;
         full_ff     <= full;
         hit_rank_ff <= hit_rank;
         match_ff    <= match_vec;
         lru_ff      <= lru_vec;
         free_ff     <= free_vec;
      end
      res_hit_ff      <= res_hit_in;
      res_ev_valid_ff <= res_ev_valid_in;
      res_ev_key_ff   <= res_ev_key_in;
   end

   assign rsp_hit           = res_hit_ff;
   assign rsp_evicted_valid = res_ev_valid_ff;
   assign rsp_evicted_key   = res_ev_key_ff;

endmodule

@@ src/lru_key_cache.sv @@
// lru_key_cache: fully associative lru store of 32-bit keys, top level
// depends on lkc_pkg, lkc_ctrl, lkc_dpath and lru_key_cache_assert.svh
//
//   channel   ports                                       direction
//   req       req_valid req_ready req_cmd req_key         in
//   rsp       rsp_valid rsp_ready rsp_hit rsp_evicted_*   out
//   csr       csr_valid csr_ready csr_data                in
//
// per word, the parallel key compare is registered at accept, and the rank,
// store and occupancy update follows in the update state at commit
// one word in flight; the next word is taken while a result waits in rsp
// the update holds while the result register is full and rsp_ready is low
// synchronous reset clears valid bits and occupancy, sets capacity to 16, no sweep
`timescale 1ns / 1ps
`include "lru_key_cache_assert.svh"

module lru_key_cache #(
   parameter int ENTRIES = lkc_pkg::DEF_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic signed [lkc_pkg::KEY_W-1:0] req_key,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic                             rsp_evicted_valid,
   output logic signed [lkc_pkg::KEY_W-1:0] rsp_evicted_key,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lkc_pkg::CAP_W-1:0]        csr_data
);
   import lkc_pkg::*;

   lkc_cmd_type cmd;

   assign csr_ready = 1'b1;

   lkc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   lkc_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_we            (csr_valid && csr_ready),
      .csr_data          (csr_data),
      .req_cmd           (req_cmd),
      .req_key           (req_key),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_key   (rsp_evicted_key)
   );

   `LKC_ASSERT_NEXT(a_one_word_busy, req_valid && req_ready, !req_ready)
   `LKC_ASSERT_NOW(a_evict_on_miss, rsp_valid && rsp_evicted_valid, !rsp_hit)
   `LKC_ASSERT_NOW(a_evict_key_zero, rsp_valid && !rsp_evicted_valid, rsp_evicted_key == '0)

endmodule

@@ test/lkc_test_pkg.sv @@
// lkc_test_pkg: recency store that predicts every lru key cache result word
// depends on lkc_pkg
`timescale 1ns / 1ps

package lkc_test_pkg;
   import lkc_pkg::*;

   typedef struct packed {
      logic             hit;
      logic             evicted_valid;
      logic [KEY_W-1:0] evicted_key;
   } cache_result_type;

   class recency_store;
      logic [KEY_W-1:0] stored[DEF_ENTRIES];
      bit               held[DEF_ENTRIES];
      int unsigned      age[DEF_ENTRIES];
      int unsigned      fill;
      logic [CAP_W-1:0] capacity;
      cache_result_type due[$];
      int unsigned      errors;

      function new();
         foreach (held[i]) begin
            held[i] = 1'b0;
            stored[i] = '0;
            age[i] = 0;
         end
         fill = 0;
         capacity = CAP_RESET;
         errors = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         capacity = value;
      endfunction

      function int pending();
         return due.size();
      endfunction

      function void note_word(logic cmd, logic [KEY_W-1:0] key);
         int unsigned      limit;
         int               slot;
         int               oldest;
         int               i;
         bit               hit;
         bit               placed;
         cache_result_type res;
         limit = 32'(capacity);
         if (limit == 0) limit = 1;
         if (limit > DEF_ENTRIES) limit = DEF_ENTRIES;
         res = '0;
         hit = 1'b0;
         slot = 0;
         for (i = 0; i < DEF_ENTRIES; i++) begin
            if (!hit && held[i] && stored[i] == key) begin
               hit = 1'b1;
               slot = i;
            end
         end
         res.hit = hit;
         if (cmd == CMD_INSERT) begin
            if (hit) begin
               for (i = 0; i < DEF_ENTRIES; i++) begin
                  if (held[i] && age[i] < age[slot]) age[i]++;
               end
               age[slot] = 0;
            end else begin
               if (fill >= limit) begin
                  oldest = -1;
                  for (i = 0; i < DEF_ENTRIES; i++) begin
                     if (held[i] && (oldest < 0 || age[i] > age[oldest])) oldest = i;
                  end
                  if (oldest >= 0) begin
                     res.evicted_valid = 1'b1;
                     res.evicted_key = stored[oldest];
                     held[oldest] = 1'b0;
                     fill--;
                     slot = oldest;
                  end
               end
               if (!res.evicted_valid) begin
                  slot = 0;
                  placed = 1'b0;
                  for (i = 0; i < DEF_ENTRIES; i++) begin
                     if (!placed && !held[i]) begin
                        slot = i;
                        placed = 1'b1;
                     end
                  end
               end
               for (i = 0; i < DEF_ENTRIES; i++) begin
                  if (held[i]) age[i]++;
               end
               stored[slot] = key;
               held[slot] = 1'b1;
               age[slot] = 0;
               fill++;
            end
         end
         due.push_back(res);
      endfunction

      function void compare_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_word(logic hit, logic evicted_valid, logic [KEY_W-1:0] evicted_key);
         cache_result_type want;
         if (due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, expected none, actual hit %b evicted %b key %h",
                     $time, hit, evicted_valid, evicted_key);
            return;
         end
         want = due.pop_front();
         compare_field("hit", KEY_W'(want.hit), KEY_W'(hit));
         compare_field("evicted_valid", KEY_W'(want.evicted_valid), KEY_W'(evicted_valid));
         compare_field("evicted_key", want.evicted_key, evicted_key);
      endfunction
   endclass

endpackage

@@ test/lru_key_cache_test.sv @@
// lru_key_cache_test: drives lookups, inserts and capacity writes into the lru key cache
// and checks each result word against the recency store; depends on lkc_pkg, lkc_test_pkg
`timescale 1ns / 1ps

module lru_key_cache_test;
   import lkc_pkg::*;
   import lkc_test_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int SUB_WORDS   = 103;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_cmd   = CMD_LOOKUP;
   logic [KEY_W-1:0]     req_key   = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_hit;
   logic                 rsp_evicted_valid;
   logic [KEY_W-1:0]     rsp_evicted_key;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CAP_W-1:0]     csr_data  = '0;
   int                   req_gap_pct   = 0;
   int                   rsp_stall_pct = 0;
   recency_store         book = new();

   lru_key_cache #(.ENTRIES(DEF_ENTRIES)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_key           (req_key),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_key   (rsp_evicted_key),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_word(rsp_hit, rsp_evicted_valid, rsp_evicted_key);
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_word(input logic cmd, input logic [KEY_W-1:0] key);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_key   <= key;
      do @(posedge clock); while (!req_ready);
      book.note_word(cmd, key);
      @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      req_valid <= 1'b0;
      while (book.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      book.set_capacity(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [KEY_W-1:0] pool[32];
      logic [CAP_W-1:0] cap_picks[6];
      logic [CAP_W-1:0] cap;
      logic             cmd;
      logic [KEY_W-1:0] key;
      int               pool_size;
      int               mode;
      int               sub;
      int               n;
      cap_picks = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd16, 5'd3};
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      req_gap_pct   = 12;
      rsp_stall_pct = 45;
      // empty store, reset capacity
      send_word(CMD_LOOKUP, 32'h0000_0000);
      send_word(CMD_INSERT, 32'h8000_0000);
      send_word(CMD_INSERT, 32'h7FFF_FFFF);
      send_word(CMD_INSERT, 32'h0000_0000);
      send_word(CMD_INSERT, 32'hFFFF_FFFF);
      send_word(CMD_INSERT, 32'h0000_0001);
      send_word(CMD_LOOKUP, 32'hFFFF_FFFF);
      send_word(CMD_INSERT, 32'h8000_0000);
      // capacity below occupancy
      write_capacity(5'd2);
      send_word(CMD_INSERT, 32'h5555_5555);
      send_word(CMD_INSERT, 32'hAAAA_AAAA);
      send_word(CMD_LOOKUP, 32'h0000_0000);
      send_word(CMD_INSERT, 32'h5555_5555);
      // zero capacity acts as one
      write_capacity(5'd0);
      send_word(CMD_INSERT, 32'h1357_9BDF);
      send_word(CMD_LOOKUP, 32'h1357_9BDF);
      // capacity above entry count saturates
      write_capacity(5'd31);
      for (n = 0; n < 12; n++)
         send_word(CMD_INSERT, 32'h0F0F_0000 + n);

      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               req_gap_pct   = 12;
               rsp_stall_pct = 45;
            end
            1: begin
               req_gap_pct   = 45;
               rsp_stall_pct = 12;
            end
            default: begin
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (sub = 0; sub < 6; sub++) begin
            cap = (sub < 2) ? cap_picks[mode * 2 + sub] : CAP_W'($urandom_range(0, 31));
            write_capacity(cap);
            pool_size = ((int'(cap) > DEF_ENTRIES) ? DEF_ENTRIES : int'(cap)) +
                        int'($urandom_range(1, 6));
            for (n = 0; n < pool_size; n++)
               pool[n] = $urandom;
            for (n = 0; n < SUB_WORDS; n++) begin
               cmd = ($urandom_range(0, 99) < 55) ? CMD_INSERT : CMD_LOOKUP;
               key = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_size - 1)];
               send_word(cmd, key);
            end
         end
      end

      req_valid <= 1'b0;
      while (book.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (book.errors == 0 && book.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/lkc_pkg.sv
src/lkc_ctrl.sv
src/lkc_dpath.sv
src/lru_key_cache.sv
test/lkc_test_pkg.sv
test/lru_key_cache_test.sv
